FILE: hdl/column_majority_consensus_defines.svh
// assertion helpers used by cmc_ctrl, the only asserting module
`ifndef COLUMN_MAJORITY_CONSENSUS_DEFINES_SVH
`define COLUMN_MAJORITY_CONSENSUS_DEFINES_SVH

// same-cycle implication
`define CMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmc assertion failed");

// next-cycle implication
`define CMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmc assertion failed");

`endif

FILE: hdl/cmc_pkg.sv
package cmc_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int REM_W         = COUNT_WIDTH + 1;
  localparam int DIV_STEPS     = FRAC_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SYMBOL       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIGUOUS_SYMBOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COVERAGE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRACTION     = 2'd3;

  localparam logic [7:0]  GAP_RESET       = 8'd45;
  localparam logic [7:0]  AMBIGUOUS_RESET = 8'd78;
  localparam logic [15:0] MIN_COV_RESET   = 16'd1;
  localparam logic [16:0] MIN_FRAC_RESET  = 17'd0;

  // call status codes
  localparam logic [2:0] STATUS_CALLED       = 3'd0;
  localparam logic [2:0] STATUS_NO_COVERAGE  = 3'd1;
  localparam logic [2:0] STATUS_LOW_COVERAGE = 3'd2;
  localparam logic [2:0] STATUS_LOW_FRACTION = 3'd3;
  localparam logic [2:0] STATUS_TIE          = 3'd4;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_in_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  called_symbol;
    logic [15:0] depth;
    logic [16:0] top_share;
    logic [2:0]  call_status;
  } out_item_t;

  typedef struct packed {
    logic count_en;
    logic pick_en;
    logic div_step;
    logic emit;
  } cmc_cmd_t;

  typedef struct packed {
    logic div_last;
  } cmc_sts_t;

  function automatic logic base_hit(input logic [7:0] s);
    case (s)
      8'h41, 8'h61, 8'h43, 8'h63, 8'h47, 8'h67, 8'h54, 8'h74: base_hit = 1'b1;
      default: base_hit = 1'b0;
    endcase
  endfunction

  function automatic logic [1:0] base_slot(input logic [7:0] s);
    case (s)
      8'h41, 8'h61: base_slot = 2'd0;
      8'h43, 8'h63: base_slot = 2'd1;
      8'h47, 8'h67: base_slot = 2'd2;
      8'h54, 8'h74: base_slot = 2'd3;
      default:      base_slot = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] base_letter(input logic [1:0] k);
    case (k)
      2'd0:    base_letter = 8'h41;
      2'd1:    base_letter = 8'h43;
      2'd2:    base_letter = 8'h47;
      2'd3:    base_letter = 8'h54;
      default: base_letter = 8'h41;
    endcase
  endfunction

endpackage

FILE: hdl/cmc_datapath.sv
module cmc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmc_pkg::cmc_cmd_t             cmd,
  output cmc_pkg::cmc_sts_t             sts,
  input  cmc_pkg::in_item_t             in_item,
  input  logic                          cfg_we,
  input  logic [cmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cmc_pkg::out_item_t            out_item
);

  logic [7:0]                       gap_r;
  logic [7:0]                       ambig_r;
  logic [15:0]                      min_cov_r;
  logic [16:0]                      min_frac_r;

  logic [cmc_pkg::COUNT_WIDTH-1:0]  cnt_r [4];
  logic [cmc_pkg::COUNT_WIDTH-1:0]  depth_r;
  logic [1:0]                       best_k_r;
  logic                             tie_r;
  logic [cmc_pkg::REM_W-1:0]        rem_r;
  logic [cmc_pkg::FRAC_W-1:0]       quo_r;
  logic [cmc_pkg::STEP_W-1:0]       step_r;
  cmc_pkg::out_item_t               out_r;

  logic                             hit;
  logic [1:0]                       slot;
  logic [cmc_pkg::COUNT_WIDTH-1:0]  best_nxt;
  logic [1:0]                       best_k_nxt;
  logic                             tie_nxt;
  logic                             q_bit;
  logic [cmc_pkg::REM_W-1:0]        rem_sub;
  logic [cmc_pkg::REM_W-1:0]        depth_ext;
  cmc_pkg::out_item_t               out_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r      <= cmc_pkg::GAP_RESET;
      ambig_r    <= cmc_pkg::AMBIGUOUS_RESET;
      min_cov_r  <= cmc_pkg::MIN_COV_RESET;
      min_frac_r <= cmc_pkg::MIN_FRAC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cmc_pkg::REG_GAP_SYMBOL:       gap_r      <= cfg_wdata[7:0];
        cmc_pkg::REG_AMBIGUOUS_SYMBOL: ambig_r    <= cfg_wdata[7:0];
        cmc_pkg::REG_MIN_COVERAGE:     min_cov_r  <= cfg_wdata[15:0];
        cmc_pkg::REG_MIN_FRACTION:     min_frac_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // gap test first, so a gap equal to a letter never counts
  assign hit  = (in_item.symbol != gap_r) && cmc_pkg::base_hit(in_item.symbol);
  assign slot = cmc_pkg::base_slot(in_item.symbol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
      depth_r <= '0;
    end else if (cmd.emit) begin
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
      depth_r <= '0;
    end else if (cmd.count_en && hit) begin
      if (cnt_r[slot] != cmc_pkg::COUNT_MAX) cnt_r[slot] <= cnt_r[slot] + 1'b1;
      if (depth_r != cmc_pkg::COUNT_MAX) depth_r <= depth_r + 1'b1;
    end
  end

  // first maximum wins, any other equal count is a tie
  always_comb begin
    best_nxt   = cnt_r[0];
    best_k_nxt = 2'd0;
    tie_nxt    = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (cnt_r[k] > best_nxt) begin
        best_nxt   = cnt_r[k];
        best_k_nxt = 2'(k);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if ((2'(k) != best_k_nxt) && (cnt_r[k] == best_nxt)) tie_nxt = 1'b1;
    end
  end

  // restoring divide, one quotient bit a cycle; best <= depth keeps it to 17 bits
  assign depth_ext = {1'b0, depth_r};
  assign q_bit     = rem_r >= depth_ext;
  assign rem_sub   = q_bit ? (rem_r - depth_ext) : rem_r;

  always_ff @(posedge clk) begin
    if (cmd.pick_en) begin
      best_k_r <= best_k_nxt;
      tie_r    <= tie_nxt;
      rem_r    <= {1'b0, best_nxt};
      quo_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= {rem_sub[cmc_pkg::REM_W-2:0], 1'b0};
      quo_r <= {quo_r[cmc_pkg::FRAC_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.pick_en) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  assign sts.div_last = (step_r == cmc_pkg::STEP_W'(cmc_pkg::DIV_STEPS - 1));

  // floor(best*2^f/depth) < thr holds exactly when best*2^f < thr*depth
  always_comb begin
    out_nxt.depth         = depth_r;
    out_nxt.called_symbol = ambig_r;
    out_nxt.top_share     = quo_r;
    if (depth_r == '0) begin
      out_nxt.top_share   = '0;
      out_nxt.call_status = cmc_pkg::STATUS_NO_COVERAGE;
    end else if (depth_r < min_cov_r) begin
      out_nxt.call_status = cmc_pkg::STATUS_LOW_COVERAGE;
    end else if (quo_r < min_frac_r) begin
      out_nxt.call_status = cmc_pkg::STATUS_LOW_FRACTION;
    end else if (tie_r) begin
      out_nxt.call_status = cmc_pkg::STATUS_TIE;
    end else begin
      out_nxt.call_status   = cmc_pkg::STATUS_CALLED;
      out_nxt.called_symbol = cmc_pkg::base_letter(best_k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= out_nxt;
  end

  assign out_item = out_r;

endmodule

FILE: hdl/cmc_ctrl.sv
`include "column_majority_consensus_defines.svh"

module cmc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cmc_pkg::cmc_sts_t  sts,
  output cmc_pkg::cmc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_COUNT = 4'b0001,
    ST_PICK  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_stall  = (state_r != ST_COUNT);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd.count_en = 1'b0;
    cmd.pick_en  = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      ST_COUNT: begin
        cmd.count_en = accept;
        if (accept && in_last) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick_en = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // wait until the output register can take the result
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_COUNT;
        end
      end
      default: state_nxt = ST_COUNT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CMC_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_r)
  `CMC_ASSERT_NOW(a_no_overwrite, cmd.emit, !out_valid_r || !out_stall)
  `CMC_ASSERT_NEXT(a_column_end_stalls, accept && in_last, in_stall)
  `CMC_ASSERT_NEXT(a_div_to_emit, (state_r == ST_DIV) && sts.div_last, state_r == ST_EMIT)

endmodule

FILE: hdl/column_majority_consensus.sv
// column majority consensus
// in channel: in_valid / in_stall with in_item (symbol, last_in_column), one
// symbol of one aligned sequence per item. cfg channel: cfg_valid / cfg_ready
// with cfg_index and cfg_wdata; cfg_ready is always high and the user writes
// only while idle, which the block does not enforce; items inside a column are
// taken one per cycle into the A/C/G/T counters; the item carrying last_in_column
// starts the call: the PICK state takes the top count, then in the DIV state a
// restoring divider makes one quotient bit a cycle, and the EMIT state loads the
// output register; out_valid rises with that load, and in_stall stays high from
// the column end through the PICK, DIV and EMIT states
// the output register lets the next column count while a result waits; if the
// receiver still stalls the previous result, the call waits and in_stall holds
// a stalled result stays on out_item unchanged
// reset (rst_n low at a clock edge) clears the counters and output valid and
// loads the register defaults: gap '-', ambiguous 'N', min coverage 1,
// min fraction 0
module column_majority_consensus (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cmc_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cmc_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cmc_pkg::cmc_cmd_t cmd;
  cmc_pkg::cmc_sts_t sts;

  assign cfg_ready = 1'b1;

  cmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last_in_column),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule
